// ----- hdl/shtlp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package shtlp_pkg;
   localparam int TABLE_SLOTS = 64;
   localparam int KEY_MAX = 16;
   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int KPOS_W = $clog2(KEY_MAX);
   localparam int KLEN_W = $clog2(KEY_MAX + 1);
   localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [1:0] MODE_SET = 2'd0;
   localparam logic [1:0] MODE_FIND = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_UPDATED = 3'd1;
   localparam logic [2:0] ST_FOUND = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_DELETED = 3'd4;
   localparam logic [2:0] ST_FULL = 3'd5;
   localparam logic [2:0] ST_TOO_LONG = 3'd6;
   localparam logic [2:0] ST_CLEARED = 3'd7;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] key_byte;
      logic key_last;
      logic [15:0] line_number;
      logic [15:0] entry_type;
      logic [31:0] entry_location;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] slot_index;
      logic [15:0] line_out;
      logic [15:0] type_out;
      logic [31:0] location_out;
   } rsp_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      fold = (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
   endfunction
endpackage
`default_nettype wire

// ----- hdl/shtlp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module shtlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hdl/symbol_hash_table_linear_probe.sv -----
// Channel | Ports                      | Direction | Handshake
// input   | start, busy, req_item      | in        | accepted when start && !busy
// result  | rsp_valid, rsp_item        | out       | one-cycle strobe, no stall
// Key bytes that are not last go through S_HASH (hash multiply) and back to idle.
// A last byte runs a probe walk: each probed slot takes a header read, wait,
// check and advance step, plus a read and compare step per key byte compared
// on a header match; a set then copies KEY_MAX bytes, and a hit or write reads
// the slot data. Clear drops every flag at once.
// Synchronous active-high reset clears control, flags and the hash; the
// receiver cannot stall and the result strobe lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none
module symbol_hash_table_linear_probe
   import shtlp_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire req_type req_item,
   output logic rsp_valid,
   output rsp_type rsp_item
);
   typedef enum logic [3:0] {
      S_IDLE, S_HASH, S_CLEAR, S_RDHDR, S_WAITHDR, S_CHECK, S_CMPRD, S_CMP,
      S_NEXT, S_DECIDE, S_WRITE, S_RDDATA, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] hash_ff, hash_in;
   logic [KLEN_W-1:0] klen_ff, klen_in;
   logic ovf_ff, ovf_in;
   logic [7:0] fbyte_ff, fbyte_in;
   req_type req_ff, req_in;
   logic [TABLE_SLOTS-1:0] used_ff, used_in, live_ff, live_in;
   logic [SLOT_W-1:0] idx_ff, idx_in, tomb_ff, tomb_in, slot_ff, slot_in;
   logic [SLOT_W:0] cnt_ff, cnt_in;
   logic [KLEN_W-1:0] bpos_ff, bpos_in;
   logic hit_ff, hit_in, htomb_ff, htomb_in, hempty_ff, hempty_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;

   // key buffer
   logic kb_we;
   logic [KPOS_W-1:0] kb_waddr, kb_raddr;
   logic [7:0] kb_rd;
   // slot header: {len, hash}, slot data: {line, type, loc}, slot bytes
   logic hdr_we, dat_we, sb_we;
   logic [KLEN_W+31:0] hdr_rd;
   logic [63:0] dat_rd;
   logic [7:0] sb_rd;
   logic [SLOT_W+KPOS_W-1:0] sb_waddr, sb_raddr;

   shtlp_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_kbuf (
      .clock, .wr_en(kb_we), .wr_addr(kb_waddr), .wr_data(req_ff.key_byte),
      .rd_addr(kb_raddr), .rd_data(kb_rd));
   shtlp_ram #(.WIDTH(KLEN_W+32), .DEPTH(TABLE_SLOTS)) u_hdr (
      .clock, .wr_en(hdr_we), .wr_addr(slot_ff), .wr_data({klen_ff, hash_ff}),
      .rd_addr(idx_ff), .rd_data(hdr_rd));
   shtlp_ram #(.WIDTH(64), .DEPTH(TABLE_SLOTS)) u_dat (
      .clock, .wr_en(dat_we), .wr_addr(slot_ff),
      .wr_data({req_ff.line_number, req_ff.entry_type, req_ff.entry_location}),
      .rd_addr(slot_ff), .rd_data(dat_rd));
   shtlp_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS*KEY_MAX)) u_sbytes (
      .clock, .wr_en(sb_we), .wr_addr(sb_waddr), .wr_data(kb_rd),
      .rd_addr(sb_raddr), .rd_data(sb_rd));

   logic [KPOS_W-1:0] bpos_lo;
   assign bpos_lo = bpos_ff[KPOS_W-1:0];
   assign kb_waddr = klen_ff[KPOS_W-1:0];
   assign kb_raddr = bpos_lo;
   assign sb_raddr = {idx_ff, bpos_lo};
   // the copy writes each byte in the cycle after its buffer read
   logic [KPOS_W-1:0] cpos_ff, cpos_in;
   logic cpy_ff, cpy_in;
   assign sb_waddr = {slot_ff, cpos_ff};
   assign sb_we = cpy_ff;

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_item = rsp_ff;

   always_comb begin
      state_in = state_ff; hash_in = hash_ff; klen_in = klen_ff; ovf_in = ovf_ff;
      fbyte_in = fbyte_ff; req_in = req_ff; used_in = used_ff; live_in = live_ff;
      idx_in = idx_ff; tomb_in = tomb_ff; slot_in = slot_ff; cnt_in = cnt_ff;
      bpos_in = bpos_ff; hit_in = hit_ff; htomb_in = htomb_ff; hempty_in = hempty_ff;
      rv_in = 1'b0; rsp_in = rsp_ff; cpos_in = cpos_ff; cpy_in = 1'b0;
      kb_we = 1'b0; hdr_we = 1'b0; dat_we = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               fbyte_in = fold(req_item.key_byte);
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (klen_ff < KLEN_W'(KEY_MAX)) begin
               kb_we = 1'b1;
               klen_in = klen_ff + 1'b1;
               hash_in = (hash_ff ^ {24'd0, fbyte_ff}) * FNV_PRIME;
            end else begin
               ovf_in = 1'b1;
            end
            if (!req_ff.key_last) state_in = S_IDLE;
            else if (req_ff.mode == MODE_CLEAR) begin
               used_in = '0; live_in = '0;
               state_in = S_CLEAR;
            end else if (ovf_in) begin
               rsp_in = '0; rsp_in.status = ST_TOO_LONG;
               state_in = S_RESP;
            end else begin
               idx_in = hash_in[SLOT_W-1:0];
               cnt_in = '0; hit_in = 1'b0; htomb_in = 1'b0; hempty_in = 1'b0;
               state_in = S_RDHDR;
            end
         end
         S_CLEAR: begin
            rsp_in = '0; rsp_in.status = ST_CLEARED;
            state_in = S_RESP;
         end
         S_RDHDR: state_in = S_WAITHDR;
         S_WAITHDR: state_in = S_CHECK;
         S_CHECK: begin
            if (live_ff[idx_ff] && hdr_rd == {klen_ff, hash_ff}) begin
               bpos_in = '0;
               state_in = S_CMPRD;
            end else if (!used_ff[idx_ff]) begin
               hempty_in = 1'b1; slot_in = idx_ff; state_in = S_DECIDE;
            end else begin
               if (!htomb_ff && !live_ff[idx_ff]) begin
                  htomb_in = 1'b1; tomb_in = idx_ff;
               end
               state_in = S_NEXT;
            end
         end
         S_CMPRD: state_in = S_CMP;
         S_CMP: begin
            if (fold(kb_rd) != fold(sb_rd)) state_in = S_NEXT;
            else if (bpos_ff + 1'b1 >= klen_ff) begin
               hit_in = 1'b1; slot_in = idx_ff; state_in = S_DECIDE;
            end else begin
               bpos_in = bpos_ff + 1'b1; state_in = S_CMPRD;
            end
         end
         S_NEXT: begin
            cnt_in = cnt_ff + 1'b1;
            idx_in = idx_ff + 1'b1;
            if (cnt_in == (SLOT_W+1)'(TABLE_SLOTS)) state_in = S_DECIDE;
            else state_in = S_RDHDR;
         end
         S_DECIDE: begin
            bpos_in = '0;
            if (req_ff.mode == MODE_SET) begin
               if (!hit_ff && htomb_ff) slot_in = tomb_ff;
               if (!hit_ff && !htomb_ff && !hempty_ff) begin
                  rsp_in = '0; rsp_in.status = ST_FULL; state_in = S_RESP;
               end else begin
                  state_in = S_WRITE;
               end
            end else if (!hit_ff) begin
               rsp_in = '0; rsp_in.status = ST_NOT_FOUND; state_in = S_RESP;
            end else begin
               state_in = S_RDDATA;
               bpos_in = {1'b0, {KPOS_W{1'b0}}};
            end
         end
         S_WRITE: begin
            // stream key buffer into slot bytes, one byte a cycle
            cpy_in = 1'b1; cpos_in = bpos_lo;
            if (bpos_ff + 1'b1 >= KLEN_W'(KEY_MAX)) begin
               hdr_we = 1'b1; dat_we = 1'b1;
               used_in[slot_ff] = 1'b1; live_in[slot_ff] = 1'b1;
               state_in = S_RDDATA;
            end else bpos_in = bpos_ff + 1'b1;
         end
         S_RDDATA: begin
            // data RAM read of slot_ff; bpos_ff marks the wait before dat_rd is taken
            if (bpos_ff != '1) bpos_in = '1;
            else begin
               rsp_in.slot_index = 6'(slot_ff);
               {rsp_in.line_out, rsp_in.type_out, rsp_in.location_out} = dat_rd;
               case (req_ff.mode)
                  MODE_SET: rsp_in.status = hit_ff ? ST_UPDATED : ST_INSERTED;
                  MODE_FIND: rsp_in.status = ST_FOUND;
                  default: begin
                     rsp_in.status = ST_DELETED;
                     live_in[slot_ff] = 1'b0;
                  end
               endcase
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rv_in = 1'b1;
            klen_in = '0; ovf_in = 1'b0; hash_in = FNV_OFFSET;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; hash_ff <= FNV_OFFSET; klen_ff <= '0; ovf_ff <= 1'b0;
         used_ff <= '0; live_ff <= '0; rv_ff <= 1'b0; cpy_ff <= 1'b0;
      end else begin
         state_ff <= state_in; hash_ff <= hash_in; klen_ff <= klen_in; ovf_ff <= ovf_in;
         used_ff <= used_in; live_ff <= live_in; rv_ff <= rv_in; cpy_ff <= cpy_in;
      end
      fbyte_ff <= fbyte_in; req_ff <= req_in; idx_ff <= idx_in; tomb_ff <= tomb_in;
      slot_ff <= slot_in; cnt_ff <= cnt_in; bpos_ff <= bpos_in; hit_ff <= hit_in;
      htomb_ff <= htomb_in; hempty_ff <= hempty_in; rsp_ff <= rsp_in; cpos_ff <= cpos_in;
   end

   a_live_used: assert property (@(posedge clock) disable iff (reset)
      (live_ff & ~used_ff) == '0) else $error("live slot not marked used");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == S_IDLE) else $error("result while busy");
   a_klen: assert property (@(posedge clock) disable iff (reset)
      klen_ff <= KLEN_W'(KEY_MAX)) else $error("key length overrun");
   a_rsp_restart: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> klen_ff == '0 && hash_ff == FNV_OFFSET) else $error("key not restarted");
endmodule
`default_nettype wire
